### sv/bqd_pkg.sv
`timescale 1ns / 1ps

package bqd_pkg;

    // coefficient format and configuration port
    localparam int COEF_W     = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2   = 3'd5;

    // program counter
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_WAIT = 3'd0;
    localparam step_t STEP_OUT  = 3'd6;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        CS_A1,
        CS_A2,
        CS_B0,
        CS_B1,
        CS_B2
    } coef_sel_t;

    typedef enum logic [1:0] {
        OS_D1,
        OS_D2,
        OS_W
    } opnd_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_INPUT,
        JMP_OUTPUT
    } jump_t;

    // one microcode word
    typedef struct packed {
        acc_op_t   acc_op;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        logic      w_we;
        jump_t     jump;
        step_t     target;
    } uword_t;

    // datapath control from the sequencer
    typedef struct packed {
        acc_op_t   acc_op;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        logic      w_we;
        logic      load_x;
        logic      commit;
    } ctrl_t;

    // microcode rom
    function automatic uword_t ucode(input step_t step);
        uword_t uw;
        uw = '{acc_op: ACC_HOLD, coef_sel: CS_A1, opnd_sel: OS_D1, w_we: 1'b0,
               jump: JMP_NEXT, target: STEP_WAIT};
        unique case (step)
            // wait for a word, bypass goes straight to the output step
            3'd0: begin
                uw.jump   = JMP_INPUT;
                uw.target = STEP_OUT;
            end
            // acc = half + a1*d1
            3'd1: begin
                uw.acc_op   = ACC_LOAD;
                uw.coef_sel = CS_A1;
                uw.opnd_sel = OS_D1;
            end
            // acc += a2*d2
            3'd2: begin
                uw.acc_op   = ACC_ADD;
                uw.coef_sel = CS_A2;
                uw.opnd_sel = OS_D2;
            end
            // latch w, acc = half + b1*d1
            3'd3: begin
                uw.acc_op   = ACC_LOAD;
                uw.coef_sel = CS_B1;
                uw.opnd_sel = OS_D1;
                uw.w_we     = 1'b1;
            end
            // acc += b2*d2
            3'd4: begin
                uw.acc_op   = ACC_ADD;
                uw.coef_sel = CS_B2;
                uw.opnd_sel = OS_D2;
            end
            // acc += b0*w
            3'd5: begin
                uw.acc_op   = ACC_ADD;
                uw.coef_sel = CS_B0;
                uw.opnd_sel = OS_W;
            end
            // saturate into the output register and shift delays, or pass x with the filter off
            3'd6: begin
                uw.jump   = JMP_OUTPUT;
                uw.target = STEP_WAIT;
            end
            default: begin
                uw.jump   = JMP_OUTPUT;
                uw.target = STEP_WAIT;
            end
        endcase
        return uw;
    endfunction

endpackage

### sv/second_order_lowpass_biquad_unit.sv
`timescale 1ns / 1ps

// Direct form II biquad low-pass filter with five programmable Q2.16
// coefficients (b0, b1, b2, a1, a2) and a filter enable. Each input word is
// one signed sample and gives one output word. One shared multiply-accumulate
// unit, stepped by a small microcode program, forms w = x - a1*d1 - a2*d2
// (replaced by x when it leaves the state range) and y = b0*w + b1*d1 + b2*d2,
// each sum rounded half up and y saturated to the sample range. A filtered
// word reaches the output register after five multiply-accumulate steps and
// then the commit step; the next word is accepted only once the program is
// back in its wait step, so the seven program steps run for each word. With
// the filter off an accepted word goes straight to the commit step and the
// delays hold. The output register lets the next word be accepted while a
// result waits for m_ready; a second result stalls in the commit step until
// the first one leaves. Configuration writes are taken at any time but must
// only be issued while the block is idle; indexes beyond the register list
// are ignored.
module second_order_lowpass_biquad_unit #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16,
    parameter int STATE_WIDTH    = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input samples
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_sample_in,
    // filtered samples
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       m_filtered_out,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bqd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bqd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic                               filter_on_reg;
    logic signed [bqd_pkg::COEF_W-1:0]  coef_b0_reg;
    logic signed [bqd_pkg::COEF_W-1:0]  coef_b1_reg;
    logic signed [bqd_pkg::COEF_W-1:0]  coef_b2_reg;
    logic signed [bqd_pkg::COEF_W-1:0]  coef_a1_reg;
    logic signed [bqd_pkg::COEF_W-1:0]  coef_a2_reg;

    bqd_pkg::ctrl_t ctrl;
    logic           out_free;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_on_reg <= 1'b0;
            coef_b0_reg   <= '0;
            coef_b1_reg   <= '0;
            coef_b2_reg   <= '0;
            coef_a1_reg   <= '0;
            coef_a2_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bqd_pkg::CFG_FILTER_ON: filter_on_reg <= cfg_data[0];
                bqd_pkg::CFG_COEF_B0:   coef_b0_reg   <= cfg_data[bqd_pkg::COEF_W-1:0];
                bqd_pkg::CFG_COEF_B1:   coef_b1_reg   <= cfg_data[bqd_pkg::COEF_W-1:0];
                bqd_pkg::CFG_COEF_B2:   coef_b2_reg   <= cfg_data[bqd_pkg::COEF_W-1:0];
                bqd_pkg::CFG_COEF_A1:   coef_a1_reg   <= cfg_data[bqd_pkg::COEF_W-1:0];
                bqd_pkg::CFG_COEF_A2:   coef_a2_reg   <= cfg_data[bqd_pkg::COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // microcode sequencer
    bqd_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .filter_on (filter_on_reg),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    // multiply-accumulate datapath
    bqd_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_WIDTH    (STATE_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .filter_on    (filter_on_reg),
        .coef_b0      (coef_b0_reg),
        .coef_b1      (coef_b1_reg),
        .coef_b2      (coef_b2_reg),
        .coef_a1      (coef_a1_reg),
        .coef_a2      (coef_a2_reg),
        .sample_in    (s_sample_in),
        .out_free     (out_free),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .filtered_out (m_filtered_out)
    );

endmodule

### sv/bqd_seq.sv
`timescale 1ns / 1ps

module bqd_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           filter_on,
    input  logic           out_free,
    output bqd_pkg::ctrl_t ctrl
);

    bqd_pkg::step_t  step_reg;
    bqd_pkg::step_t  step_next;
    bqd_pkg::uword_t uw;

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= bqd_pkg::STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    // rom lookup, jumps and control decode
    always_comb begin
        uw            = bqd_pkg::ucode(step_reg);
        step_next     = step_reg + bqd_pkg::step_t'(1);
        ctrl.acc_op   = uw.acc_op;
        ctrl.coef_sel = uw.coef_sel;
        ctrl.opnd_sel = uw.opnd_sel;
        ctrl.w_we     = uw.w_we;
        ctrl.load_x   = 1'b0;
        ctrl.commit   = 1'b0;
        s_ready       = 1'b0;
        unique case (uw.jump)
            bqd_pkg::JMP_INPUT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load_x = 1'b1;
                    if (!filter_on) begin
                        step_next = uw.target;
                    end
                end else begin
                    step_next = step_reg;
                end
            end
            bqd_pkg::JMP_OUTPUT: begin
                if (out_free) begin
                    ctrl.commit = 1'b1;
                    step_next   = uw.target;
                end else begin
                    step_next = step_reg;
                end
            end
            default: begin
                step_next = step_reg + bqd_pkg::step_t'(1);
            end
        endcase
    end

endmodule

### sv/bqd_dp.sv
`timescale 1ns / 1ps

module bqd_dp #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16,
    parameter int STATE_WIDTH    = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  bqd_pkg::ctrl_t                          ctrl,
    input  logic                                    filter_on,
    input  logic signed [bqd_pkg::COEF_W-1:0]       coef_b0,
    input  logic signed [bqd_pkg::COEF_W-1:0]       coef_b1,
    input  logic signed [bqd_pkg::COEF_W-1:0]       coef_b2,
    input  logic signed [bqd_pkg::COEF_W-1:0]       coef_a1,
    input  logic signed [bqd_pkg::COEF_W-1:0]       coef_a2,
    input  logic signed [SAMPLE_WIDTH-1:0]          sample_in,
    output logic                                    out_free,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]          filtered_out
);

    localparam int PROD_W = bqd_pkg::COEF_W + STATE_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0]   x_reg;
    logic signed [STATE_WIDTH-1:0]    d1_reg;
    logic signed [STATE_WIDTH-1:0]    d2_reg;
    logic signed [STATE_WIDTH-1:0]    w_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [ACC_W-1:0]          acc_next;
    logic signed [SAMPLE_WIDTH-1:0]   out_reg;
    logic                             out_valid_reg;

    logic signed [bqd_pkg::COEF_W-1:0] coef_mux;
    logic signed [STATE_WIDTH-1:0]     opnd_mux;
    logic signed [PROD_W-1:0]          prod;
    logic signed [ACC_W-1:0]           q;
    logic signed [ACC_W:0]             w_full;
    logic                              w_fits;
    logic signed [STATE_WIDTH-1:0]     w_next;
    logic                              y_fits;
    logic signed [SAMPLE_WIDTH-1:0]    y_sat;

    // operand selection and the shared multiplier
    always_comb begin
        unique case (ctrl.coef_sel)
            bqd_pkg::CS_A1: coef_mux = coef_a1;
            bqd_pkg::CS_A2: coef_mux = coef_a2;
            bqd_pkg::CS_B0: coef_mux = coef_b0;
            bqd_pkg::CS_B1: coef_mux = coef_b1;
            bqd_pkg::CS_B2: coef_mux = coef_b2;
            default:        coef_mux = coef_a1;
        endcase
        unique case (ctrl.opnd_sel)
            bqd_pkg::OS_D1: opnd_mux = d1_reg;
            bqd_pkg::OS_D2: opnd_mux = d2_reg;
            bqd_pkg::OS_W:  opnd_mux = w_reg;
            default:        opnd_mux = d1_reg;
        endcase
        prod = PROD_W'(coef_mux) * PROD_W'(opnd_mux);
    end

    // accumulator update
    always_comb begin
        unique case (ctrl.acc_op)
            bqd_pkg::ACC_LOAD: acc_next = HALF + ACC_W'(prod);
            bqd_pkg::ACC_ADD:  acc_next = acc_reg + ACC_W'(prod);
            default:           acc_next = acc_reg;
        endcase
    end

    // rounded sum, new delay value with range guard, output saturation
    always_comb begin
        q      = acc_reg >>> COEF_FRAC_BITS;
        w_full = (ACC_W + 1)'(x_reg) - (ACC_W + 1)'(q);
        w_fits = (&w_full[ACC_W:STATE_WIDTH-1]) | ~(|w_full[ACC_W:STATE_WIDTH-1]);
        w_next = w_fits ? w_full[STATE_WIDTH-1:0] : STATE_WIDTH'(x_reg);
        y_fits = (&q[ACC_W-1:SAMPLE_WIDTH-1]) | ~(|q[ACC_W-1:SAMPLE_WIDTH-1]);
        if (y_fits) begin
            y_sat = q[SAMPLE_WIDTH-1:0];
        end else if (q[ACC_W-1]) begin
            y_sat = SMIN;
        end else begin
            y_sat = SMAX;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (ctrl.load_x) begin
            x_reg <= sample_in;
        end
        if (ctrl.w_we) begin
            w_reg <= w_next;
        end
        if (ctrl.commit) begin
            out_reg <= filter_on ? y_sat : x_reg;
        end
    end

    // delay line, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else if (ctrl.commit && filter_on) begin
            d2_reg <= d1_reg;
            d1_reg <= w_reg;
        end
    end

    // output word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_free     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign filtered_out = out_reg;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int SMP_W  = 16;
    localparam int FRAC_W = 16;
    localparam int ST_W   = 32;

    localparam int RANDOM_ITEMS   = 928;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int MAX_PRINTED    = 30;

    typedef logic signed [SMP_W-1:0]           sample_t;
    typedef logic signed [ST_W-1:0]            state_t;
    typedef logic signed [bqd_pkg::COEF_W-1:0] coef_t;
    typedef logic [bqd_pkg::CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [bqd_pkg::CFG_DATA_W-1:0]    cfg_data_t;

    // indexes past the register list
    localparam cfg_idx_t CFG_SPARE_LO = 3'd6;
    localparam cfg_idx_t CFG_SPARE_HI = 3'd7;

    localparam coef_t K_MAX  = 19'sh3FFFF;
    localparam coef_t K_MIN  = 19'sh40000;
    localparam coef_t K_ONE  = 19'sd65536;
    localparam coef_t K_HALF = 19'sd32768;
    localparam coef_t K_ZERO = 19'sd0;

    localparam sample_t SMP_MAX = 16'sh7FFF;
    localparam sample_t SMP_MIN = 16'sh8000;

    localparam longint ROUND_HALF = longint'(1) << (FRAC_W - 1);
    localparam longint STATE_HI   = (longint'(1) << (ST_W - 1)) - 1;
    localparam longint STATE_LO   = -STATE_HI - 1;
    localparam longint OUT_HI     = (longint'(1) << (SMP_W - 1)) - 1;
    localparam longint OUT_LO     = -OUT_HI - 1;

    logic      aclk;
    logic      aresetn     = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    sample_t   s_sample_in = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    sample_t   m_filtered_out;
    logic      cfg_valid   = 1'b0;
    logic      cfg_ready;
    cfg_idx_t  cfg_index   = '0;
    cfg_data_t cfg_data    = '0;

    // filter image: registers and delay line
    logic   f_on;
    coef_t  k_b0, k_b1, k_b2, k_a1, k_a2;
    state_t dly_one, dly_two;

    sample_t expected_out[$];

    int  n_errors;
    int  n_sent;
    int  n_random;
    int  n_results;
    int  n_settings;
    int  n_guard;
    int  n_clip;
    bit  pace_on;
    int  sink_hold;

    second_order_lowpass_biquad_unit #(
        .SAMPLE_WIDTH  (SMP_W),
        .COEF_FRAC_BITS(FRAC_W),
        .STATE_WIDTH   (ST_W)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered_out(m_filtered_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_fault(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED) $display("[%0t] error: %s", $time, msg);
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // multiply-accumulate sum scaled down, rounded half up
    function automatic longint scale_round(input longint acc);
        return (acc + ROUND_HALF) >>> FRAC_W;
    endfunction

    // next output of the filter, advances the delay line when the filter is on
    function automatic sample_t biquad_next(input sample_t x);
        longint w;
        longint y;
        if (!f_on) return x;
        w = longint'(x) - scale_round(longint'(k_a1) * longint'(dly_one)
                                      + longint'(k_a2) * longint'(dly_two));
        if (w > STATE_HI || w < STATE_LO) begin
            w = longint'(x);
            n_guard++;
        end
        y = scale_round(longint'(k_b0) * w + longint'(k_b1) * longint'(dly_one)
                        + longint'(k_b2) * longint'(dly_two));
        dly_two = dly_one;
        dly_one = state_t'(w);
        if (y > OUT_HI || y < OUT_LO) n_clip++;
        if (y > OUT_HI) y = OUT_HI;
        if (y < OUT_LO) y = OUT_LO;
        return sample_t'(y);
    endfunction

    // result side: random stalls
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (pace_on && $urandom_range(0, 99) < 20) begin
            sink_hold <= pick_gap();
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each output word with the oldest expectation
    always @(posedge aclk) begin : check_results
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_out.size() == 0) begin
                report_fault($sformatf("unexpected output word %0d", m_filtered_out));
            end else begin
                want = expected_out.pop_front();
                if (m_filtered_out !== want)
                    report_fault($sformatf("filtered_out %0d, expected %0d",
                                           m_filtered_out, want));
            end
        end
    end

    // stop when no word moves on any channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a word moving", quiet);
        $display("CHECK FAILED");
        $finish;
    end

    // one register write, valid left high for the caller to drop
    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bqd_pkg::CFG_FILTER_ON: f_on = val[0];
            bqd_pkg::CFG_COEF_B0:   k_b0 = coef_t'(val);
            bqd_pkg::CFG_COEF_B1:   k_b1 = coef_t'(val);
            bqd_pkg::CFG_COEF_B2:   k_b2 = coef_t'(val);
            bqd_pkg::CFG_COEF_A1:   k_a1 = coef_t'(val);
            bqd_pkg::CFG_COEF_A2:   k_a2 = coef_t'(val);
            default: ;
        endcase
    endtask

    // full register set, sometimes with a write to a spare index
    task automatic program_filter(input logic on, input coef_t b0, input coef_t b1,
                                  input coef_t b2, input coef_t a1, input coef_t a2);
        cfg_data_t on_word;
        on_word    = cfg_data_t'($urandom());
        on_word[0] = on;
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      cfg_data_t'($urandom()));
        write_reg(bqd_pkg::CFG_COEF_B0, cfg_data_t'(b0));
        write_reg(bqd_pkg::CFG_COEF_B1, cfg_data_t'(b1));
        write_reg(bqd_pkg::CFG_COEF_B2, cfg_data_t'(b2));
        write_reg(bqd_pkg::CFG_COEF_A1, cfg_data_t'(a1));
        write_reg(bqd_pkg::CFG_COEF_A2, cfg_data_t'(a2));
        write_reg(bqd_pkg::CFG_FILTER_ON, on_word);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // one input word, expectation pushed on acceptance
    task automatic send_sample(input sample_t x);
        int gap;
        gap = pace_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        do @(posedge aclk); while (!s_ready);
        expected_out.push_back(biquad_next(x));
        n_sent++;
    endtask

    // block idle once every expected word is back
    task automatic wait_for_outputs();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_out.size() != 0);
    endtask

    // filter off: extremes pass through unchanged
    task automatic test_passthrough();
        pace_on = 1'b1;
        program_filter(1'b0, coef_t'($urandom()), coef_t'($urandom()), coef_t'($urandom()),
                       coef_t'($urandom()), coef_t'($urandom()));
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        wait_for_outputs();
    endtask

    // b0 = 0.5: ties round half up on both signs
    task automatic test_rounding();
        program_filter(1'b1, K_HALF, K_ZERO, K_ZERO, K_ZERO, K_ZERO);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
        wait_for_outputs();
    endtask

    // largest gains clip the output both ways
    task automatic test_saturation();
        program_filter(1'b1, K_MAX, K_MAX, K_MAX, K_ZERO, K_ZERO);
        send_sample(SMP_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_MIN);
        wait_for_outputs();
    endtask

    // a1 = -4 blows up the delay until the range guard takes the sample
    task automatic test_state_overflow();
        program_filter(1'b1, coef_t'(19'sd1024), K_ZERO, K_ZERO, K_MIN, K_ZERO);
        repeat (10) send_sample(SMP_MAX);
        wait_for_outputs();
    endtask

    function automatic coef_t edge_coef();
        case ($urandom_range(0, 3))
            0: return K_MIN;
            1: return K_MAX;
            2: return K_ONE;
            default: return K_ZERO;
        endcase
    endfunction

    function automatic sample_t pick_sample(input sample_t prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return sample_t'($urandom());
        if (r < 70) return sample_t'($urandom_range(0, 511) - 256);
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return SMP_MIN;
                1: return SMP_MAX;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        return prev;
    endfunction

    // phases of random length, each with its own register setting
    task automatic test_random_settings();
        int     kind;
        int     phase_len;
        int     ta1;
        int     ta2;
        int     tb;
        logic   on;
        coef_t  c0, c1, c2, c3, c4;
        sample_t x;
        x = '0;
        while (n_random < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            on   = 1'b1;
            if (kind < 30) begin
                // stable low-pass shape
                tb  = $urandom_range(0, 16384);
                ta2 = $urandom_range(0, 60000);
                ta1 = -int'($urandom_range(0, 64536 + ta2));
                c0 = coef_t'(tb);
                c1 = coef_t'(2 * tb);
                c2 = coef_t'(tb);
                c3 = coef_t'(ta1);
                c4 = coef_t'(ta2);
            end else if (kind < 70) begin
                c0 = coef_t'($urandom());
                c1 = coef_t'($urandom());
                c2 = coef_t'($urandom());
                c3 = coef_t'($urandom());
                c4 = coef_t'($urandom());
            end else if (kind < 80) begin
                c0 = edge_coef();
                c1 = edge_coef();
                c2 = edge_coef();
                c3 = edge_coef();
                c4 = edge_coef();
            end else if (kind < 90) begin
                on = 1'b0;
                c0 = coef_t'($urandom());
                c1 = coef_t'($urandom());
                c2 = coef_t'($urandom());
                c3 = coef_t'($urandom());
                c4 = coef_t'($urandom());
            end else begin
                // small gains
                c0 = coef_t'(int'($urandom_range(0, 8191)) - 4096);
                c1 = coef_t'(int'($urandom_range(0, 8191)) - 4096);
                c2 = coef_t'(int'($urandom_range(0, 8191)) - 4096);
                c3 = coef_t'(int'($urandom_range(0, 8191)) - 4096);
                c4 = coef_t'(int'($urandom_range(0, 8191)) - 4096);
            end
            pace_on = ($urandom_range(0, 3) != 0);
            program_filter(on, c0, c1, c2, c3, c4);
            phase_len = $urandom_range(20, 80);
            if (phase_len > RANDOM_ITEMS - n_random) phase_len = RANDOM_ITEMS - n_random;
            repeat (phase_len) begin
                x = pick_sample(x);
                send_sample(x);
                n_random++;
            end
            wait_for_outputs();
        end
    endtask

    initial begin
        f_on    = 1'b0;
        k_b0    = '0;
        k_b1    = '0;
        k_b2    = '0;
        k_a1    = '0;
        k_a2    = '0;
        dly_one = '0;
        dly_two = '0;
        pace_on = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_rounding();
        test_saturation();
        test_state_overflow();
        test_random_settings();

        pace_on = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_out.size() != 0)
            report_fault($sformatf("%0d output words never arrived", expected_out.size()));

        $display("%0d samples sent (%0d random) over %0d register settings, %0d outputs checked",
                 n_sent, n_random, n_settings, n_results);
        $display("delay range guard taken %0d times, output clipped %0d times",
                 n_guard, n_clip);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
